FILE: design/tdpa_pkg.sv
`timescale 1ns / 1ps

package tdpa_pkg;

	localparam int WORD_WIDTH = 32;
	localparam int FRAC_BITS  = 16;

	// Magnitude of a + |z|, the sum of squares, its root and the remainder of the root cells.
	localparam int AZ_W   = WORD_WIDTH + 1;
	localparam int D_W    = 2 * WORD_WIDTH + 2;
	localparam int HALF_W = D_W / 2;
	localparam int ROOT_W = WORD_WIDTH + 1;
	localparam int RM_W   = ROOT_W + 2;

	// Numerators and denominators of the dividers.
	localparam int PN_W = WORD_WIDTH + FRAC_BITS;
	localparam int AN_W = WORD_WIDTH + AZ_W + 2 * FRAC_BITS;
	localparam int DS_W = D_W + ROOT_W;
	localparam int Q_W  = WORD_WIDTH;

	localparam int CFG_IDX_W = 2;
	localparam int DIMS_W    = 2;
	localparam logic [DIMS_W-1:0] DIMS_RESET = 2'd3;
	localparam logic [WORD_WIDTH-1:0] ONE_FIX = WORD_WIDTH'(1) << FRAC_BITS;

	localparam logic [WORD_WIDTH-1:0] MIN_MAG = {1'b1, {(WORD_WIDTH-1){1'b0}}};
	localparam logic [WORD_WIDTH-1:0] MAX_POS = {1'b0, {(WORD_WIDTH-1){1'b1}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POINT_MASS   = 2'd0,
		REG_SCALE_LENGTH = 2'd1,
		REG_ACTIVE_DIMS  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic signed [WORD_WIDTH-1:0] pos_x;
		logic signed [WORD_WIDTH-1:0] pos_y;
		logic signed [WORD_WIDTH-1:0] pos_z;
	} pos_t;

	typedef struct packed {
		logic signed [WORD_WIDTH-1:0] potential;
		logic signed [WORD_WIDTH-1:0] accel_x;
		logic signed [WORD_WIDTH-1:0] accel_y;
		logic signed [WORD_WIDTH-1:0] accel_z;
		logic                         saturated;
	} res_t;

	// Data that travels alongside the root cells.
	typedef struct packed {
		logic [D_W-1:0]        d;
		logic [WORD_WIDTH-1:0] mx;
		logic [WORD_WIDTH-1:0] my;
		logic [AZ_W-1:0]       baz;
		logic                  px;
		logic                  py;
		logic                  pz;
		logic                  z_zero;
		logic                  d_zero;
	} front_t;

	// Flags that travel alongside the divider cells.
	typedef struct packed {
		logic px;
		logic py;
		logic pz;
		logic z_zero;
		logic d_zero;
	} back_t;

	// Applies the sign to a quotient magnitude and clamps it; the top bit is the clamp flag.
	function automatic logic [WORD_WIDTH:0] emit(input logic [Q_W-1:0] q, input logic ovf,
			input logic neg);
		logic                  big;
		logic [WORD_WIDTH-1:0] v;
		if (neg) begin
			big = ovf || (q > MIN_MAG);
			v   = big ? MIN_MAG : WORD_WIDTH'('0 - q);
		end else begin
			big = ovf || q[Q_W-1];
			v   = big ? MAX_POS : q;
		end
		return {big, v};
	endfunction

endpackage

FILE: design/tdpa_sqrt_cell.sv
`timescale 1ns / 1ps

module tdpa_sqrt_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         valid_in,
	input  tdpa_pkg::front_t             side_in,
	input  logic [tdpa_pkg::RM_W-1:0]    rem_in,
	input  logic [tdpa_pkg::ROOT_W-1:0]  root_in,
	input  logic [tdpa_pkg::D_W-1:0]     dr_in,
	output logic                         valid_out,
	output tdpa_pkg::front_t             side_out,
	output logic [tdpa_pkg::RM_W-1:0]    rem_out,
	output logic [tdpa_pkg::ROOT_W-1:0]  root_out,
	output logic [tdpa_pkg::D_W-1:0]     dr_out
);

	logic [tdpa_pkg::RM_W+1:0] t;
	logic [tdpa_pkg::RM_W+1:0] trial;
	logic [tdpa_pkg::RM_W+1:0] diff;
	logic                      ge;

	// One root bit per cell: bring down the next pair of radicand bits and try 4r+1.
	always_comb begin
		t     = {rem_in, dr_in[tdpa_pkg::D_W-1 -: 2]};
		trial = {{(tdpa_pkg::RM_W - tdpa_pkg::ROOT_W){1'b0}}, root_in, 2'b01};
		diff  = t - trial;
		ge    = (t >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_out <= side_in;
			rem_out  <= ge ? diff[tdpa_pkg::RM_W-1:0] : t[tdpa_pkg::RM_W-1:0];
			root_out <= {root_in[tdpa_pkg::ROOT_W-2:0], ge};
			dr_out   <= {dr_in[tdpa_pkg::D_W-3:0], 2'b00};
		end
	end

endmodule

FILE: design/tdpa_div_cell.sv
`timescale 1ns / 1ps

module tdpa_div_cell #(
	parameter int DEN_W = 34,
	parameter int Q_W   = 32
) (
	input  logic             clk,
	input  logic             en,
	input  logic [DEN_W-1:0] rem_in,
	input  logic [DEN_W-1:0] den_in,
	input  logic [Q_W-1:0]   nlow_in,
	input  logic [Q_W-1:0]   q_in,
	input  logic             ovf_in,
	output logic [DEN_W-1:0] rem_out,
	output logic [DEN_W-1:0] den_out,
	output logic [Q_W-1:0]   nlow_out,
	output logic [Q_W-1:0]   q_out,
	output logic             ovf_out
);

	logic [DEN_W:0] t;
	logic [DEN_W:0] diff;
	logic           ge;

	// One restoring step: shift in the next numerator bit, subtract when it fits.
	always_comb begin
		t    = {rem_in, nlow_in[Q_W-1]};
		diff = t - {1'b0, den_in};
		ge   = (t >= {1'b0, den_in});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_out  <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
			den_out  <= den_in;
			nlow_out <= {nlow_in[Q_W-2:0], 1'b0};
			q_out    <= {q_in[Q_W-2:0], ge};
			ovf_out  <= ovf_in;
		end
	end

endmodule

FILE: design/tdpa_div_lane.sv
`timescale 1ns / 1ps

module tdpa_div_lane #(
	parameter int N_W   = 48,
	parameter int DEN_W = 34,
	parameter int Q_W   = 32
) (
	input  logic             clk,
	input  logic             en,
	input  logic [N_W-1:0]   num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   q,
	output logic             ovf
);

	localparam int HI_W = N_W - Q_W;
	localparam int CW   = (HI_W > DEN_W) ? HI_W : DEN_W;

	logic [CW-1:0] hi_ext;
	logic [CW-1:0] den_ext;
	logic          big;

	logic [DEN_W-1:0] rem_w  [0:Q_W];
	logic [DEN_W-1:0] den_w  [0:Q_W];
	logic [Q_W-1:0]   nlow_w [0:Q_W];
	logic [Q_W-1:0]   q_w    [0:Q_W];
	logic             ovf_w  [0:Q_W];

	// A quotient that needs more than Q_W bits is flagged here and clamped later.
	always_comb begin
		hi_ext  = CW'(num[N_W-1:Q_W]);
		den_ext = CW'(den);
		big     = (hi_ext >= den_ext);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_w[0]  <= big ? '0 : hi_ext[DEN_W-1:0];
			den_w[0]  <= den;
			nlow_w[0] <= num[Q_W-1:0];
			q_w[0]    <= '0;
			ovf_w[0]  <= big;
		end
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_cell
		tdpa_div_cell #(
			.DEN_W(DEN_W),
			.Q_W  (Q_W)
		) u_cell (
			.clk     (clk),
			.en      (en),
			.rem_in  (rem_w[k]),
			.den_in  (den_w[k]),
			.nlow_in (nlow_w[k]),
			.q_in    (q_w[k]),
			.ovf_in  (ovf_w[k]),
			.rem_out (rem_w[k+1]),
			.den_out (den_w[k+1]),
			.nlow_out(nlow_w[k+1]),
			.q_out   (q_w[k+1]),
			.ovf_out (ovf_w[k+1])
		);
	end

	assign q   = q_w[Q_W];
	assign ovf = ovf_w[Q_W];

endmodule

FILE: design/thin_disk_potential_accel_top.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// pos       in         pos_valid / pos_stall     tdpa_pkg::pos_t  (pos_x, pos_y, pos_z)
// res       out        res_valid / res_stall     tdpa_pkg::res_t  (potential, accelerations, flag)
// cfg       in         cfg_we                    cfg_index, cfg_data
//
// One position is taken every cycle while pos_stall is low.
// The pipeline runs through the 33 root cells and the 32 divider cells of the four quotient lanes.
// The whole pipeline advances together; it holds only while a result waits under res_stall,
// and pos_stall is raised exactly then.
// Reset clears all valid bits and loads the configuration defaults; there is no clearing pass.

module thin_disk_potential_accel_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  pos_valid,
	output logic                                  pos_stall,
	input  tdpa_pkg::pos_t                        pos_data,
	output logic                                  res_valid,
	input  logic                                  res_stall,
	output tdpa_pkg::res_t                        res_data,
	input  logic                                  cfg_we,
	input  logic [tdpa_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [tdpa_pkg::WORD_WIDTH-1:0]       cfg_data
);

	localparam int W  = tdpa_pkg::WORD_WIDTH;
	localparam int BD = tdpa_pkg::Q_W + 1;

	logic en;

	logic [W-1:0]                point_mass_q;
	logic [W-1:0]                scale_length_q;
	logic [tdpa_pkg::DIMS_W-1:0] active_dims_q;

	logic              valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	tdpa_pkg::front_t  f_in, f_s1, f_s2, f_s3;
	tdpa_pkg::front_t  f_d2;
	logic [2*W-1:0]    sqx_s2, sqy_s2;
	logic [2*tdpa_pkg::AZ_W-1:0] sqz_s2;
	logic [tdpa_pkg::D_W-1:0]    d_sum;

	logic             sq_valid [0:tdpa_pkg::ROOT_W];
	tdpa_pkg::front_t sq_side  [0:tdpa_pkg::ROOT_W];
	logic [tdpa_pkg::RM_W-1:0]   sq_rem  [0:tdpa_pkg::ROOT_W];
	logic [tdpa_pkg::ROOT_W-1:0] sq_root [0:tdpa_pkg::ROOT_W];
	logic [tdpa_pkg::D_W-1:0]    sq_dr   [0:tdpa_pkg::ROOT_W];

	tdpa_pkg::front_t f_end;
	logic [tdpa_pkg::HALF_W+tdpa_pkg::ROOT_W-1:0] dsh_s4, dsl_s4;
	logic [2*W-1:0]                 mcx_s4, mcy_s4, mcx_s5, mcy_s5;
	logic [W+tdpa_pkg::AZ_W-1:0]    mcz_s4, mcz_s5;
	logic [tdpa_pkg::ROOT_W-1:0]    s_s4, s_s5;
	logic [tdpa_pkg::DS_W-1:0]      den_s5;
	tdpa_pkg::back_t                b_s4, b_s5;

	logic            bk_valid_q [0:BD-1];
	tdpa_pkg::back_t bk_q       [0:BD-1];

	logic [tdpa_pkg::Q_W-1:0] qp, qx, qy, qz;
	logic                     op, ox, oy, oz;

	tdpa_pkg::res_t res_n;
	tdpa_pkg::res_t res_data_q;
	logic           res_valid_q;

	assign en        = !(res_valid_q && res_stall);
	assign pos_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_mass_q   <= tdpa_pkg::ONE_FIX;
			scale_length_q <= tdpa_pkg::ONE_FIX;
			active_dims_q  <= tdpa_pkg::DIMS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tdpa_pkg::REG_POINT_MASS:   point_mass_q   <= cfg_data;
				tdpa_pkg::REG_SCALE_LENGTH: scale_length_q <= cfg_data;
				tdpa_pkg::REG_ACTIVE_DIMS:  active_dims_q  <= cfg_data[tdpa_pkg::DIMS_W-1:0];
				default: ;
			endcase
		end
	end

	// Magnitudes and sign flags; the most negative input keeps its magnitude 2^(W-1).
	always_comb begin
		f_in        = '0;
		f_in.mx     = pos_data.pos_x[W-1] ? W'('0 - pos_data.pos_x) : pos_data.pos_x;
		f_in.my     = pos_data.pos_y[W-1] ? W'('0 - pos_data.pos_y) : pos_data.pos_y;
		f_in.baz    = tdpa_pkg::AZ_W'(scale_length_q)
			+ tdpa_pkg::AZ_W'(pos_data.pos_z[W-1] ? W'('0 - pos_data.pos_z) : pos_data.pos_z);
		f_in.px     = !pos_data.pos_x[W-1] && (pos_data.pos_x != '0);
		f_in.py     = !pos_data.pos_y[W-1] && (pos_data.pos_y != '0);
		f_in.pz     = !pos_data.pos_z[W-1] && (pos_data.pos_z != '0);
		f_in.z_zero = (pos_data.pos_z == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pos_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	assign d_sum = tdpa_pkg::D_W'(sqx_s2) + tdpa_pkg::D_W'(sqy_s2) + sqz_s2;

	always_comb begin
		f_d2        = f_s2;
		f_d2.d      = d_sum;
		f_d2.d_zero = (d_sum == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s1   <= f_in;
			f_s2   <= f_s1;
			sqx_s2 <= f_s1.mx * f_s1.mx;
			sqy_s2 <= f_s1.my * f_s1.my;
			sqz_s2 <= f_s1.baz * f_s1.baz;
			f_s3   <= f_d2;
		end
	end

	assign sq_valid[0] = valid_s3;
	assign sq_side[0]  = f_s3;
	assign sq_rem[0]   = '0;
	assign sq_root[0]  = '0;
	assign sq_dr[0]    = f_s3.d;

	for (genvar k = 0; k < tdpa_pkg::ROOT_W; k++) begin : g_sqrt
		tdpa_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (sq_valid[k]),
			.side_in  (sq_side[k]),
			.rem_in   (sq_rem[k]),
			.root_in  (sq_root[k]),
			.dr_in    (sq_dr[k]),
			.valid_out(sq_valid[k+1]),
			.side_out (sq_side[k+1]),
			.rem_out  (sq_rem[k+1]),
			.root_out (sq_root[k+1]),
			.dr_out   (sq_dr[k+1])
		);
	end

	assign f_end = sq_side[tdpa_pkg::ROOT_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s4 <= sq_valid[tdpa_pkg::ROOT_W];
			valid_s5 <= valid_s4;
		end
	end

	// The denominator d*s is built from two half-width partial products.
	always_ff @(posedge clk) begin
		if (en) begin
			dsh_s4 <= f_end.d[tdpa_pkg::D_W-1:tdpa_pkg::HALF_W] * sq_root[tdpa_pkg::ROOT_W];
			dsl_s4 <= f_end.d[tdpa_pkg::HALF_W-1:0] * sq_root[tdpa_pkg::ROOT_W];
			mcx_s4 <= point_mass_q * f_end.mx;
			mcy_s4 <= point_mass_q * f_end.my;
			mcz_s4 <= point_mass_q * f_end.baz;
			s_s4   <= sq_root[tdpa_pkg::ROOT_W];
			b_s4   <= '{px: f_end.px, py: f_end.py, pz: f_end.pz,
				z_zero: f_end.z_zero, d_zero: f_end.d_zero};
			den_s5 <= (tdpa_pkg::DS_W'(dsh_s4) << tdpa_pkg::HALF_W) + tdpa_pkg::DS_W'(dsl_s4);
			mcx_s5 <= mcx_s4;
			mcy_s5 <= mcy_s4;
			mcz_s5 <= mcz_s4;
			s_s5   <= s_s4;
			b_s5   <= b_s4;
		end
	end

	tdpa_div_lane #(.N_W(tdpa_pkg::PN_W), .DEN_W(tdpa_pkg::ROOT_W), .Q_W(tdpa_pkg::Q_W)) u_pot (
		.clk(clk), .en(en),
		.num({point_mass_q, {tdpa_pkg::FRAC_BITS{1'b0}}}),
		.den(s_s5), .q(qp), .ovf(op)
	);

	tdpa_div_lane #(.N_W(tdpa_pkg::AN_W), .DEN_W(tdpa_pkg::DS_W), .Q_W(tdpa_pkg::Q_W)) u_ax (
		.clk(clk), .en(en),
		.num({1'b0, mcx_s5, {(2*tdpa_pkg::FRAC_BITS){1'b0}}}),
		.den(den_s5), .q(qx), .ovf(ox)
	);

	tdpa_div_lane #(.N_W(tdpa_pkg::AN_W), .DEN_W(tdpa_pkg::DS_W), .Q_W(tdpa_pkg::Q_W)) u_ay (
		.clk(clk), .en(en),
		.num({1'b0, mcy_s5, {(2*tdpa_pkg::FRAC_BITS){1'b0}}}),
		.den(den_s5), .q(qy), .ovf(oy)
	);

	tdpa_div_lane #(.N_W(tdpa_pkg::AN_W), .DEN_W(tdpa_pkg::DS_W), .Q_W(tdpa_pkg::Q_W)) u_az (
		.clk(clk), .en(en),
		.num({mcz_s5, {(2*tdpa_pkg::FRAC_BITS){1'b0}}}),
		.den(den_s5), .q(qz), .ovf(oz)
	);

	// Flags follow the divider lanes through a delay line of the same depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BD; i++) begin
				bk_valid_q[i] <= 1'b0;
			end
		end else if (en) begin
			bk_valid_q[0] <= valid_s5;
			for (int i = 1; i < BD; i++) begin
				bk_valid_q[i] <= bk_valid_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bk_q[0] <= b_s5;
			for (int i = 1; i < BD; i++) begin
				bk_q[i] <= bk_q[i-1];
			end
		end
	end

	always_comb begin
		logic [W:0]      ep, ex, ey, ez;
		tdpa_pkg::back_t b;
		b  = bk_q[BD-1];
		ep = tdpa_pkg::emit(qp, op, 1'b1);
		ex = (active_dims_q >= 2'd1) ? tdpa_pkg::emit(qx, ox, b.px) : '0;
		ey = (active_dims_q >= 2'd2) ? tdpa_pkg::emit(qy, oy, b.py) : '0;
		ez = (active_dims_q == 2'd3 && !b.z_zero) ? tdpa_pkg::emit(qz, oz, b.pz) : '0;
		res_n.potential = ep[W-1:0];
		res_n.accel_x   = ex[W-1:0];
		res_n.accel_y   = ey[W-1:0];
		res_n.accel_z   = ez[W-1:0];
		res_n.saturated = ep[W] | ex[W] | ey[W] | ez[W];
		// At the singular point the potential pins to its most negative value.
		if (b.d_zero) begin
			res_n.potential = tdpa_pkg::MIN_MAG;
			res_n.accel_x   = '0;
			res_n.accel_y   = '0;
			res_n.accel_z   = '0;
			res_n.saturated = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= bk_valid_q[BD-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_data_q <= res_n;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_data_q;

endmodule

FILE: design/tdpa_checker.sv
`timescale 1ns / 1ps

module tdpa_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           pos_valid,
	input logic           pos_stall,
	input logic           res_valid,
	input logic           res_stall,
	input tdpa_pkg::res_t res_data
);

	// A result held under stall stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result changed while stalled");

	// The input side only stalls behind a waiting result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pos_stall |-> res_valid && res_stall)
		else $error("input stalled without a waiting result");

	// The potential is never positive.
	a_pot_sign: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_data.potential[tdpa_pkg::WORD_WIDTH-1] || res_data.potential == '0)
		else $error("positive potential");

	// With no result waiting, a new position is always taken.
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		pos_valid && !res_valid |-> !pos_stall)
		else $error("input stalled while output empty");

endmodule

bind thin_disk_potential_accel_top tdpa_checker u_tdpa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pos_valid(pos_valid),
	.pos_stall(pos_stall),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res_data (res_data)
);

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import tdpa_pkg::*;

	localparam int LATENCY     = 72;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk;
	logic arst_n;
	logic pos_valid;
	logic pos_stall;
	pos_t pos_data;
	logic res_valid;
	logic res_stall;
	res_t res_data;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_WIDTH-1:0] cfg_data;

	thin_disk_potential_accel_top uut (
		.clk(clk), .arst_n(arst_n),
		.pos_valid(pos_valid), .pos_stall(pos_stall), .pos_data(pos_data),
		.res_valid(res_valid), .res_stall(res_stall), .res_data(res_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Shadow of the configuration registers.
	logic [WORD_WIDTH-1:0] mass_q;
	logic [WORD_WIDTH-1:0] scale_q;
	logic [DIMS_W-1:0]     dims_q;

	res_t expected_fields[$];
	int   send_idle_pct;
	int   recv_idle_pct;
	int   hold_off_cycles;
	int   error_count;
	int   cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [127:0] isqrt(input logic [127:0] d);
		logic [127:0] r;
		logic [127:0] t;
		r = '0;
		for (int b = 40; b >= 0; b--) begin
			t = r | (128'd1 << b);
			if (t * t <= d)
				r = t;
		end
		return isqrt_done(r);
	endfunction

	function automatic logic [127:0] isqrt_done(input logic [127:0] r);
		return r;
	endfunction

	// Signs and clamps one quotient magnitude.
	function automatic logic [WORD_WIDTH-1:0] clamp_signed(input logic [127:0] q, input logic neg,
			inout logic sat);
		if (neg) begin
			if (q > 128'(MIN_MAG)) begin
				sat = 1'b1;
				return MIN_MAG;
			end
			return WORD_WIDTH'(0) - q[WORD_WIDTH-1:0];
		end
		if (q > 128'(MAX_POS)) begin
			sat = 1'b1;
			return MAX_POS;
		end
		return q[WORD_WIDTH-1:0];
	endfunction

	function automatic res_t disk_field(input pos_t p);
		res_t r;
		logic [127:0] mag[3];
		logic         positive[3];
		logic [WORD_WIDTH-1:0] raw[3];
		logic [127:0] baz, d, s, ds, q, comp;
		logic [WORD_WIDTH-1:0] acc[3];
		logic sat;
		raw[0] = p.pos_x;
		raw[1] = p.pos_y;
		raw[2] = p.pos_z;
		for (int i = 0; i < 3; i++) begin
			mag[i]      = raw[i][WORD_WIDTH-1] ? (128'd1 << WORD_WIDTH) - 128'(raw[i])
				: 128'(raw[i]);
			positive[i] = !raw[i][WORD_WIDTH-1] && raw[i] != '0;
			acc[i]      = '0;
		end
		sat = 1'b0;
		baz = 128'(scale_q) + mag[2];
		d   = mag[0] * mag[0] + mag[1] * mag[1] + baz * baz;
		if (d == '0) begin
			r.potential = MIN_MAG;
			r.accel_x   = '0;
			r.accel_y   = '0;
			r.accel_z   = '0;
			r.saturated = 1'b1;
			return r;
		end
		s  = isqrt(d);
		q  = (128'(mass_q) << FRAC_BITS) / s;
		r.potential = clamp_signed(q, 1'b1, sat);
		ds = d * s;
		for (int i = 0; i < 3 && i < int'(dims_q); i++) begin
			// The in-plane case has no vertical pull.
			if (!(i == 2 && mag[2] == '0)) begin
				comp   = (i == 2) ? baz : mag[i];
				q      = ((128'(mass_q) * comp) << (2 * FRAC_BITS)) / ds;
				acc[i] = clamp_signed(q, positive[i], sat);
			end
		end
		r.accel_x   = acc[0];
		r.accel_y   = acc[1];
		r.accel_z   = acc[2];
		r.saturated = sat;
		return r;
	endfunction

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: random stall plus an optional long hold-off.
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_fields.size() == 0) begin
				$display("%0t: unexpected result %h", $time, res_data);
				error_count++;
			end else begin
				want = expected_fields.pop_front();
				if (want.potential !== res_data.potential) begin
					$display("%0t: potential expected %h actual %h", $time,
						want.potential, res_data.potential);
					error_count++;
				end
				if (want.accel_x !== res_data.accel_x) begin
					$display("%0t: accel_x expected %h actual %h", $time,
						want.accel_x, res_data.accel_x);
					error_count++;
				end
				if (want.accel_y !== res_data.accel_y) begin
					$display("%0t: accel_y expected %h actual %h", $time,
						want.accel_y, res_data.accel_y);
					error_count++;
				end
				if (want.accel_z !== res_data.accel_z) begin
					$display("%0t: accel_z expected %h actual %h", $time,
						want.accel_z, res_data.accel_z);
					error_count++;
				end
				if (want.saturated !== res_data.saturated) begin
					$display("%0t: saturated expected %b actual %b", $time,
						want.saturated, res_data.saturated);
					error_count++;
				end
			end
		end
	end

	task automatic send_position(input pos_t p);
		pos_valid <= 1'b1;
		pos_data  <= p;
		@(posedge clk);
		while (pos_stall)
			@(posedge clk);
		expected_fields.push_back(disk_field(p));
		if ($urandom_range(0, 99) < send_idle_pct) begin
			pos_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain;
		pos_valid <= 1'b0;
		while (expected_fields.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
	endtask

	// The enable drops again after each write.
	task automatic write_reg(input reg_idx_t idx, input logic [WORD_WIDTH-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_POINT_MASS:   mass_q  = value;
			REG_SCALE_LENGTH: scale_q = value;
			REG_ACTIVE_DIMS:  dims_q  = value[DIMS_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	function automatic logic [WORD_WIDTH-1:0] rand_coord;
		logic [WORD_WIDTH-1:0] v;
		v = $urandom;
		case ($urandom_range(0, 4))
			0: return v;
			1: return '0;
			default: return WORD_WIDTH'($signed(v) >>> $urandom_range(8, 31));
		endcase
	endfunction

	task automatic test_directed;
		logic [WORD_WIDTH-1:0] edges[5];
		pos_t p;
		edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, ONE_FIX};
		foreach (edges[i]) begin
			p = '{edges[i], edges[(i + 1) % 5], edges[(i + 2) % 5]};
			send_position(p);
		end
		send_position('{32'h0, 32'h0, 32'h0});
		send_position('{ONE_FIX, 32'h0, -ONE_FIX});
		send_position('{32'h1, 32'h1, 32'h1});
		send_position('{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
		drain();
	endtask

	task automatic test_random(input int count, input int s_pct, input int r_pct);
		pos_t p;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		repeat (count) begin
			p = '{rand_coord(), rand_coord(), rand_coord()};
			send_position(p);
		end
		drain();
	endtask

	task automatic test_backpressure;
		send_idle_pct   = 0;
		recv_idle_pct   = 0;
		hold_off_cycles = 300;
		repeat (150)
			send_position('{rand_coord(), rand_coord(), rand_coord()});
		drain();
	endtask

	task automatic test_settings;
		write_reg(REG_POINT_MASS, 32'h1);
		write_reg(REG_SCALE_LENGTH, 32'h1);
		write_reg(REG_ACTIVE_DIMS, 32'd1);
		test_directed();
		test_random(200, 33, 65);
		write_reg(REG_POINT_MASS, 32'hffff_ffff);
		write_reg(REG_SCALE_LENGTH, 32'hffff_ffff);
		write_reg(REG_ACTIVE_DIMS, 32'd2);
		test_directed();
		test_random(200, 65, 33);
		write_reg(REG_POINT_MASS, $urandom | 32'h1);
		write_reg(REG_SCALE_LENGTH, ($urandom >> $urandom_range(0, 24)) | 32'h1);
		write_reg(REG_ACTIVE_DIMS, 32'd3);
		test_random(300, 0, 0);
		write_reg(REG_POINT_MASS, 32'h0100_0000);
		write_reg(REG_SCALE_LENGTH, 32'h0000_8000);
		test_random(300, 33, 65);
	endtask

	initial begin
		arst_n          = 1'b0;
		pos_valid       = 1'b0;
		pos_data        = '0;
		res_stall       = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		send_idle_pct   = 33;
		recv_idle_pct   = 65;
		hold_off_cycles = 0;
		error_count     = 0;
		cycle_count     = 0;
		mass_q          = ONE_FIX;
		scale_q         = ONE_FIX;
		dims_q          = DIMS_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(350, 33, 65);
		test_random(350, 65, 33);
		test_random(300, 0, 0);
		test_backpressure();
		test_settings();

		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: filelist.f
design/tdpa_pkg.sv
design/tdpa_sqrt_cell.sv
design/tdpa_div_cell.sv
design/tdpa_div_lane.sv
design/thin_disk_potential_accel_top.sv
design/tdpa_checker.sv
bench/tb_top.sv
